// ----- hdl/sbtr_pkg.sv -----
// Shared types and constants of the scaled bitmap text renderer.
`default_nettype none
package sbtr_pkg;

  localparam int OPCODE_W = 2;
  localparam int CODE_W   = 8;
  localparam int POS_W    = 8;
  localparam int INDEX_W  = 11;
  localparam int BYTE_W   = 8;
  localparam int COORD_W  = 9;
  localparam int SCALE_W  = 4;
  localparam int ROW_W    = 3;
  localparam int GLYPH_ROWS = 8;

  localparam int ADVANCE_CELLS = 6;
  localparam int LINE_CELLS    = 8;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd2;

  localparam logic REG_SCALE_X = 1'b0;
  localparam logic REG_SCALE_Y = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic newline;
    logic begin_char;
    logic latch;
    logic emit;
    logic next_col;
    logic flush;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                newline;
    logic                code_ok;
    logic                bits_zero;
    logic                last_col;
    logic                pend_valid;
    logic                out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/sbtr_ifs.sv -----
// Stream interfaces for text items and rectangle commands.
`default_nettype none
interface sbtr_in_if;
  logic                               valid;
  logic                               ready;
  logic [sbtr_pkg::OPCODE_W-1:0]      opcode;
  logic [sbtr_pkg::CODE_W-1:0]        char_code;
  logic [sbtr_pkg::POS_W-1:0]         pos_x;
  logic [sbtr_pkg::POS_W-1:0]         pos_y;
  logic [sbtr_pkg::INDEX_W-1:0]       font_index;
  logic [sbtr_pkg::BYTE_W-1:0]        font_byte;
  modport source (output valid, opcode, char_code, pos_x, pos_y, font_index, font_byte,
                  input ready);
  modport sink (input valid, opcode, char_code, pos_x, pos_y, font_index, font_byte,
                output ready);
endinterface

interface sbtr_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbtr_pkg::COORD_W-1:0]  rect_x;
  logic [sbtr_pkg::COORD_W-1:0]  rect_y;
  logic [sbtr_pkg::SCALE_W-1:0]  rect_w;
  logic [sbtr_pkg::SCALE_W-1:0]  rect_h;
  logic                          last_rect;
  modport source (output valid, rect_x, rect_y, rect_w, rect_h, last_rect, input ready);
  modport sink (input valid, rect_x, rect_y, rect_w, rect_h, last_rect, output ready);
endinterface
`default_nettype wire

// ----- hdl/sbtr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1280
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/sbtr_ctrl.sv -----
// Control state machine: accepts text items and sequences glyph columns, rows and the final flush.
`default_nettype none
module sbtr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbtr_pkg::status_t status,
  output sbtr_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_LATCH = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (status.opcode)
            sbtr_pkg::OP_LOAD:  cmd.load  = 1'b1;
            sbtr_pkg::OP_START: cmd.start = 1'b1;
            sbtr_pkg::OP_DRAW: begin
              if (status.newline) begin
                cmd.newline = 1'b1;
              end else begin
                cmd.begin_char = 1'b1;
                state_next     = status.code_ok ? S_FETCH : S_FLUSH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.bits_zero) begin
          if (status.last_col) begin
            state_next = S_FLUSH;
          end else begin
            cmd.next_col = 1'b1;
            state_next   = S_FETCH;
          end
        end else if (!status.pend_valid || status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush   = 1'b1;
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sbtr_dp.sv -----
// Datapath: glyph memory, cursor, scale registers, pending and output rectangle.
`default_nettype none
module sbtr_dp #(
  parameter int GLYPH_COUNT   = 256,
  parameter int GLYPH_COLUMNS = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sbtr_pkg::cmd_t                    cmd,
  output sbtr_pkg::status_t                      status,
  input  wire logic [sbtr_pkg::OPCODE_W-1:0]     opcode,
  input  wire logic [sbtr_pkg::CODE_W-1:0]       char_code,
  input  wire logic [sbtr_pkg::POS_W-1:0]        pos_x,
  input  wire logic [sbtr_pkg::POS_W-1:0]        pos_y,
  input  wire logic [sbtr_pkg::INDEX_W-1:0]      font_index,
  input  wire logic [sbtr_pkg::BYTE_W-1:0]       font_byte,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [sbtr_pkg::SCALE_W-1:0]      cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [sbtr_pkg::COORD_W-1:0]      rect_x,
  output logic      [sbtr_pkg::COORD_W-1:0]      rect_y,
  output logic      [sbtr_pkg::SCALE_W-1:0]      rect_w,
  output logic      [sbtr_pkg::SCALE_W-1:0]      rect_h,
  output logic                                   last_rect
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_COLUMNS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = GLYPH_COLUMNS > 1 ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int XW    = CW + sbtr_pkg::SCALE_W;
  localparam int YW    = sbtr_pkg::ROW_W + sbtr_pkg::SCALE_W;

  logic [sbtr_pkg::SCALE_W-1:0] scale_x;
  logic [sbtr_pkg::SCALE_W-1:0] scale_y;
  logic [sbtr_pkg::POS_W-1:0]   cursor_x;
  logic [sbtr_pkg::POS_W-1:0]   cursor_y;
  logic [sbtr_pkg::POS_W-1:0]   margin_x;
  logic [AW-1:0]                code_base;
  logic [CW-1:0]                col;
  logic [sbtr_pkg::BYTE_W-1:0]  bits;
  logic                         pend_valid;
  logic [sbtr_pkg::COORD_W-1:0] pend_x;
  logic [sbtr_pkg::COORD_W-1:0] pend_y;

  logic                         ram_we;
  logic [AW-1:0]                rd_addr;
  logic [sbtr_pkg::BYTE_W-1:0]  rd_data;
  logic [sbtr_pkg::ROW_W-1:0]   row;
  logic                         row_found;
  logic [XW-1:0]                x_off;
  logic [YW-1:0]                y_off;
  logic [sbtr_pkg::COORD_W-1:0] new_x;
  logic [sbtr_pkg::COORD_W-1:0] new_y;
  logic                         out_free;

  assign ram_we  = cmd.load && ({21'd0, font_index} < 32'(DEPTH));
  assign rd_addr = code_base + AW'(col);

  sbtr_ram #(
    .WIDTH (sbtr_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_glyph_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (font_index[AW-1:0]),
    .wr_data (font_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Lowest set bit of the current column is the next dot to draw.
  always_comb begin
    row       = '0;
    row_found = 1'b0;
    for (int i = 0; i < sbtr_pkg::GLYPH_ROWS; i++) begin
      if (!row_found && bits[i]) begin
        row       = sbtr_pkg::ROW_W'(i);
        row_found = 1'b1;
      end
    end
  end

  assign x_off    = XW'(col) * XW'(scale_x);
  assign y_off    = YW'(row) * YW'(scale_y);
  assign new_x    = sbtr_pkg::COORD_W'(cursor_x) + sbtr_pkg::COORD_W'(x_off);
  assign new_y    = sbtr_pkg::COORD_W'(cursor_y) + sbtr_pkg::COORD_W'(y_off);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    status            = '0;
    status.opcode     = opcode;
    status.newline    = (char_code == sbtr_pkg::NEWLINE_CODE);
    status.code_ok    = (32'(char_code) < 32'(GLYPH_COUNT));
    status.bits_zero  = (bits == '0);
    status.last_col   = (col == CW'(GLYPH_COLUMNS - 1));
    status.pend_valid = pend_valid;
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= sbtr_pkg::SCALE_RESET;
      scale_y <= sbtr_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbtr_pkg::REG_SCALE_X: scale_x <= cfg_data;
        sbtr_pkg::REG_SCALE_Y: scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      margin_x <= '0;
    end else if (cmd.start) begin
      cursor_x <= pos_x;
      cursor_y <= pos_y;
      margin_x <= pos_x;
    end else if (cmd.newline) begin
      cursor_x <= margin_x;
      cursor_y <= cursor_y + sbtr_pkg::POS_W'(sbtr_pkg::LINE_CELLS * scale_y);
    end else if (cmd.advance) begin
      cursor_x <= cursor_x + sbtr_pkg::POS_W'(sbtr_pkg::ADVANCE_CELLS * scale_x);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.begin_char) begin
      code_base <= AW'(32'(char_code) * GLYPH_COLUMNS);
      col       <= '0;
    end else if (cmd.next_col) begin
      col <= col + CW'(1);
    end
    if (cmd.latch) begin
      bits <= rd_data;
    end else if (cmd.emit) begin
      bits <= bits & (bits - sbtr_pkg::BYTE_W'(1));
    end
  end

  // A rectangle is held back one step so the final one of a character can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
    if (cmd.emit) begin
      pend_x <= new_x;
      pend_y <= new_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush || (cmd.emit && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.flush || (cmd.emit && pend_valid)) begin
      rect_x    <= pend_x;
      rect_y    <= pend_y;
      rect_w    <= scale_x;
      rect_h    <= scale_y;
      last_rect <= cmd.flush;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/scaled_bitmap_text_renderer.sv -----
// Top level of the scaled bitmap text renderer.
// Usage: text items enter on txt_in; each is a glyph byte load, a start that
// sets cursor and left margin, or a character to draw. Rectangle commands
// leave on rect_out, one per set glyph dot, with last_rect on the final one.
// Scale registers are written on cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// Loads, starts, newlines and unused opcodes are taken without leaving idle.
// A drawn character is accepted; if its code is below GLYPH_COUNT, each
// glyph column then costs a memory read, a latch and an end check, and each
// set dot a step of the row scan. A flush step closes the character. The
// first rectangle appears once the second dot is found, or at the end of the
// character for a one-dot glyph.
// The output is a register: a new item is taken while a result waits. When
// the receiver stalls, the scan holds until the output register frees up.
// Reset returns the controller to idle, clears cursor and margin, sets both
// scales to 2 and drops any waiting beat; glyph memory keeps its contents
// and is undefined until loaded.
`default_nettype none
module scaled_bitmap_text_renderer #(
  parameter int GLYPH_COUNT   = 256,
  parameter int GLYPH_COLUMNS = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sbtr_in_if.sink                           txt_in,
  sbtr_out_if.source                        rect_out,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [sbtr_pkg::SCALE_W-1:0] cfg_data
);

  sbtr_pkg::cmd_t    cmd;
  sbtr_pkg::status_t status;

  sbtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (txt_in.valid),
    .in_ready (txt_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sbtr_dp #(
    .GLYPH_COUNT   (GLYPH_COUNT),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (txt_in.opcode),
    .char_code  (txt_in.char_code),
    .pos_x      (txt_in.pos_x),
    .pos_y      (txt_in.pos_y),
    .font_index (txt_in.font_index),
    .font_byte  (txt_in.font_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (rect_out.valid),
    .out_ready  (rect_out.ready),
    .rect_x     (rect_out.rect_x),
    .rect_y     (rect_out.rect_y),
    .rect_w     (rect_out.rect_w),
    .rect_h     (rect_out.rect_h),
    .last_rect  (rect_out.last_rect)
  );

endmodule
`default_nettype wire

// ----- hdl/sbtr_checker.sv -----
// Port-level checker for the text renderer and its bind to the top level.
`default_nettype none
module sbtr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [sbtr_pkg::OPCODE_W-1:0] opcode,
  input wire logic [sbtr_pkg::CODE_W-1:0]   char_code,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sbtr_pkg::COORD_W-1:0]  rect_x,
  input wire logic [sbtr_pkg::COORD_W-1:0]  rect_y,
  input wire logic [sbtr_pkg::SCALE_W-1:0]  rect_w,
  input wire logic [sbtr_pkg::SCALE_W-1:0]  rect_h,
  input wire logic                          last_rect
);

  // A stalled beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rect_x) && $stable(rect_y)
      && $stable(rect_w) && $stable(rect_h) && $stable(last_rect))
    else $error("rectangle beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Loads and starts leave the block ready for the next item.
  a_single_cycle_ops: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready
      && (opcode == sbtr_pkg::OP_LOAD || opcode == sbtr_pkg::OP_START) |=> in_ready)
    else $error("load or start did not return to ready");

  a_newline_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == sbtr_pkg::OP_DRAW
      && char_code == sbtr_pkg::NEWLINE_CODE |=> in_ready)
    else $error("newline did not return to ready");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("ready dropped without an accepted beat");

endmodule

bind scaled_bitmap_text_renderer sbtr_checker u_sbtr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (txt_in.valid),
  .in_ready  (txt_in.ready),
  .opcode    (txt_in.opcode),
  .char_code (txt_in.char_code),
  .out_valid (rect_out.valid),
  .out_ready (rect_out.ready),
  .rect_x    (rect_out.rect_x),
  .rect_y    (rect_out.rect_y),
  .rect_w    (rect_out.rect_w),
  .rect_h    (rect_out.rect_h),
  .last_rect (rect_out.last_rect)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the scaled bitmap text renderer.
`default_nettype none
module tb_top;

  localparam int FONT_CODES    = 256;
  localparam int FONT_COLS     = 5;
  localparam int STORE_DEPTH   = FONT_CODES * FONT_COLS;
  localparam int INDEX_MAX     = (1 << sbtr_pkg::INDEX_W) - 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 7;

  localparam logic [sbtr_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [sbtr_pkg::OPCODE_W-1:0] opcode;
    logic [sbtr_pkg::CODE_W-1:0]   char_code;
    logic [sbtr_pkg::POS_W-1:0]    pos_x;
    logic [sbtr_pkg::POS_W-1:0]    pos_y;
    logic [sbtr_pkg::INDEX_W-1:0]  font_index;
    logic [sbtr_pkg::BYTE_W-1:0]   font_byte;
  } text_item_t;

  typedef struct packed {
    logic [sbtr_pkg::COORD_W-1:0] rect_x;
    logic [sbtr_pkg::COORD_W-1:0] rect_y;
    logic [sbtr_pkg::SCALE_W-1:0] rect_w;
    logic [sbtr_pkg::SCALE_W-1:0] rect_h;
    logic                         last_rect;
  } rect_cmd_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [sbtr_pkg::SCALE_W-1:0] cfg_data;

  sbtr_in_if  txt_if ();
  sbtr_out_if rect_if ();

  scaled_bitmap_text_renderer #(
    .GLYPH_COUNT  (FONT_CODES),
    .GLYPH_COLUMNS(FONT_COLS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .txt_in   (txt_if),
    .rect_out (rect_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state.
  logic [sbtr_pkg::BYTE_W-1:0]  font_mem [STORE_DEPTH];
  logic [sbtr_pkg::POS_W-1:0]   pen_x      = '0;
  logic [sbtr_pkg::POS_W-1:0]   pen_y      = '0;
  logic [sbtr_pkg::POS_W-1:0]   line_start = '0;
  logic [sbtr_pkg::SCALE_W-1:0] dot_w      = sbtr_pkg::SCALE_RESET;
  logic [sbtr_pkg::SCALE_W-1:0] dot_h      = sbtr_pkg::SCALE_RESET;

  // Stimulus bookkeeping.
  bit          font_loaded [STORE_DEPTH];
  text_item_t  text_backlog [$];
  rect_cmd_t   rect_expected [$];
  int unsigned items_queued  = 0;
  int unsigned items_taken   = 0;
  int unsigned fail_count    = 0;
  int unsigned in_idle_pct   = 18;
  int unsigned out_stall_pct = 18;
  logic        in_fire;
  text_item_t  drive_item;
  logic [sbtr_pkg::SCALE_W-1:0] sx_plan [PHASES] = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd8, 4'd6};
  logic [sbtr_pkg::SCALE_W-1:0] sy_plan [PHASES] = '{4'd1, 4'd8, 4'd5, 4'd0, 4'd15, 4'd1, 4'd4};

  task automatic render_item(input text_item_t it);
    rect_cmd_t                   cmd;
    logic [sbtr_pkg::BYTE_W-1:0] column;
    int                          dots;
    int                          k;
    dots = 0;
    k = 0;
    case (it.opcode)
      sbtr_pkg::OP_LOAD: begin
        if (int'(it.font_index) < STORE_DEPTH) font_mem[it.font_index] = it.font_byte;
      end
      sbtr_pkg::OP_START: begin
        pen_x = it.pos_x;
        pen_y = it.pos_y;
        line_start = it.pos_x;
      end
      sbtr_pkg::OP_DRAW: begin
        if (it.char_code == sbtr_pkg::NEWLINE_CODE) begin
          pen_y = sbtr_pkg::POS_W'(int'(pen_y) + sbtr_pkg::LINE_CELLS * int'(dot_h));
          pen_x = line_start;
        end else begin
          if (int'(it.char_code) < FONT_CODES) begin
            for (int c = 0; c < FONT_COLS; c++) begin
              dots += $countones(font_mem[int'(it.char_code) * FONT_COLS + c]);
            end
            for (int c = 0; c < FONT_COLS; c++) begin
              column = font_mem[int'(it.char_code) * FONT_COLS + c];
              for (int r = 0; r < sbtr_pkg::GLYPH_ROWS; r++) begin
                if (column[r]) begin
                  k++;
                  cmd.rect_x = sbtr_pkg::COORD_W'(int'(pen_x) + c * int'(dot_w));
                  cmd.rect_y = sbtr_pkg::COORD_W'(int'(pen_y) + r * int'(dot_h));
                  cmd.rect_w = dot_w;
                  cmd.rect_h = dot_h;
                  cmd.last_rect = (k == dots);
                  rect_expected.push_back(cmd);
                end
              end
            end
          end
          pen_x = sbtr_pkg::POS_W'(int'(pen_x) + sbtr_pkg::ADVANCE_CELLS * int'(dot_w));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_rect(input rect_cmd_t got);
    rect_cmd_t want;
    if (rect_expected.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected rectangle, expected none, got x=%0d y=%0d w=%0d h=%0d last=%0b",
               $time, got.rect_x, got.rect_y, got.rect_w, got.rect_h, got.last_rect);
    end else begin
      want = rect_expected.pop_front();
      if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y ||
          got.rect_w !== want.rect_w || got.rect_h !== want.rect_h ||
          got.last_rect !== want.last_rect) begin
        fail_count++;
        $display({"%0t: rectangle mismatch, expected x=%0d y=%0d w=%0d h=%0d last=%0b,",
                  " got x=%0d y=%0d w=%0d h=%0d last=%0b"}, $time,
                 want.rect_x, want.rect_y, want.rect_w, want.rect_h, want.last_rect,
                 got.rect_x, got.rect_y, got.rect_w, got.rect_h, got.last_rect);
      end
    end
  endtask

  function automatic text_item_t noise_item();
    text_item_t it;
    it.opcode     = sbtr_pkg::OPCODE_W'($urandom_range(3));
    it.char_code  = sbtr_pkg::CODE_W'($urandom_range(255));
    it.pos_x      = sbtr_pkg::POS_W'($urandom_range(255));
    it.pos_y      = sbtr_pkg::POS_W'($urandom_range(255));
    it.font_index = sbtr_pkg::INDEX_W'($urandom_range(INDEX_MAX));
    it.font_byte  = sbtr_pkg::BYTE_W'($urandom_range(255));
    return it;
  endfunction

  function automatic logic [sbtr_pkg::BYTE_W-1:0] glyph_byte();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick < 2) return '0;
    if (pick == 2) return '1;
    return sbtr_pkg::BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [sbtr_pkg::CODE_W-1:0] random_code();
    if ($urandom_range(3) == 0) return sbtr_pkg::CODE_W'($urandom_range(255));
    return sbtr_pkg::CODE_W'(64 + $urandom_range(15));
  endfunction

  task automatic post_item(input text_item_t it);
    text_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic load_byte(input int idx, input logic [sbtr_pkg::BYTE_W-1:0] value);
    text_item_t it;
    it = noise_item();
    it.opcode = sbtr_pkg::OP_LOAD;
    it.font_index = sbtr_pkg::INDEX_W'(idx);
    it.font_byte = value;
    if (idx < STORE_DEPTH) font_loaded[idx] = 1'b1;
    post_item(it);
  endtask

  task automatic start_text(input logic [sbtr_pkg::POS_W-1:0] x,
                            input logic [sbtr_pkg::POS_W-1:0] y);
    text_item_t it;
    it = noise_item();
    it.opcode = sbtr_pkg::OP_START;
    it.pos_x = x;
    it.pos_y = y;
    post_item(it);
  endtask

  // Glyph columns that were never loaded get random contents before the draw.
  task automatic queue_char(input logic [sbtr_pkg::CODE_W-1:0] code);
    text_item_t it;
    if (code != sbtr_pkg::NEWLINE_CODE && int'(code) < FONT_CODES) begin
      for (int c = 0; c < FONT_COLS; c++) begin
        if (!font_loaded[int'(code) * FONT_COLS + c])
          load_byte(int'(code) * FONT_COLS + c, glyph_byte());
      end
    end
    it = noise_item();
    it.opcode = sbtr_pkg::OP_DRAW;
    it.char_code = code;
    post_item(it);
  endtask

  task automatic queue_random_text(input int target);
    text_item_t  it;
    int unsigned first;
    int unsigned pick;
    first = items_queued;
    while (items_queued - first < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_char(random_code());
      end else if (pick < 70) begin
        queue_char(sbtr_pkg::NEWLINE_CODE);
      end else if (pick < 80) begin
        start_text(sbtr_pkg::POS_W'($urandom_range(255)),
                   sbtr_pkg::POS_W'($urandom_range(255)));
      end else if (pick < 88) begin
        load_byte($urandom_range(STORE_DEPTH - 1), glyph_byte());
      end else if (pick < 94) begin
        load_byte($urandom_range(INDEX_MAX, STORE_DEPTH), glyph_byte());
      end else begin
        it = noise_item();
        it.opcode = OP_UNUSED;
        post_item(it);
      end
    end
  endtask

  task automatic write_scale(input logic idx, input logic [sbtr_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sbtr_pkg::REG_SCALE_X) dot_w = value;
    else dot_h = value;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_queued || rect_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      txt_if.valid <= 1'b0;
    end else if (!txt_if.valid || in_fire) begin
      if (text_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        drive_item = text_backlog.pop_front();
        txt_if.valid      <= 1'b1;
        txt_if.opcode     <= drive_item.opcode;
        txt_if.char_code  <= drive_item.char_code;
        txt_if.pos_x      <= drive_item.pos_x;
        txt_if.pos_y      <= drive_item.pos_y;
        txt_if.font_index <= drive_item.font_index;
        txt_if.font_byte  <= drive_item.font_byte;
      end else begin
        txt_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rect_if.ready <= !rst && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    text_item_t seen;
    rect_cmd_t  got;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= txt_if.valid && txt_if.ready;
      if (txt_if.valid && txt_if.ready) begin
        seen.opcode     = txt_if.opcode;
        seen.char_code  = txt_if.char_code;
        seen.pos_x      = txt_if.pos_x;
        seen.pos_y      = txt_if.pos_y;
        seen.font_index = txt_if.font_index;
        seen.font_byte  = txt_if.font_byte;
        render_item(seen);
        items_taken++;
      end
      if (rect_if.valid && rect_if.ready) begin
        got.rect_x    = rect_if.rect_x;
        got.rect_y    = rect_if.rect_y;
        got.rect_w    = rect_if.rect_w;
        got.rect_h    = rect_if.rect_h;
        got.last_rect = rect_if.last_rect;
        check_rect(got);
      end
    end
  end

  initial begin
    text_item_t it;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A full glyph, a single-dot glyph, a blank glyph, ignored items and wrapping.
    for (int c = 0; c < FONT_COLS; c++) load_byte(c, '1);
    for (int c = 0; c < FONT_COLS; c++)
      load_byte(255 * FONT_COLS + c, (c == FONT_COLS - 1) ? 8'h80 : 8'h00);
    for (int c = 0; c < FONT_COLS; c++) load_byte(FONT_COLS + c, '0);
    load_byte(INDEX_MAX, 8'h5A);
    load_byte(STORE_DEPTH, 8'hA5);
    it = noise_item();
    it.opcode = OP_UNUSED;
    post_item(it);
    start_text('0, '0);
    queue_char(8'd0);
    queue_char(8'd255);
    queue_char(8'd1);
    queue_char(sbtr_pkg::NEWLINE_CODE);
    start_text('1, '1);
    queue_char(8'd0);
    queue_char(sbtr_pkg::NEWLINE_CODE);
    queue_char(8'd255);
    settle();

    sx_plan[PHASES-1] = sbtr_pkg::SCALE_W'($urandom_range(8, 1));
    sy_plan[PHASES-1] = sbtr_pkg::SCALE_W'($urandom_range(8, 1));
    for (int p = 0; p < PHASES; p++) begin
      in_idle_pct   = (p == 1) ? 0 : 18;
      out_stall_pct = (p == 1) ? 0 : 18;
      write_scale(sbtr_pkg::REG_SCALE_X, sx_plan[p]);
      write_scale(sbtr_pkg::REG_SCALE_Y, sy_plan[p]);
      queue_random_text(32);
      settle();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
hdl/sbtr_pkg.sv
hdl/sbtr_ifs.sv
hdl/sbtr_ram.sv
hdl/sbtr_ctrl.sv
hdl/sbtr_dp.sv
hdl/scaled_bitmap_text_renderer.sv
hdl/sbtr_checker.sv
sim/tb_top.sv
